### design/wsfd_pkg.sv
// ---------------------------------------------------------------------------
// wsfd_pkg: shared types and constants for the frame deframer
// Widths of the byte and length fields, result kind codes, queue link type.
// ---------------------------------------------------------------------------
package wsfd_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 31;
   localparam int KIND_W = 2;

   // Largest reportable frame length; longer lengths saturate to this.
   localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_TOO_BIG = 2'd3
   } wsfd_kind_type;

   // Head of the byte queue as seen by the parser.
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data;
   } wsfd_head_type;

endpackage

### design/websocket_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer_unit: receive-side frame parser
// Parses a byte stream into frame headers, unmasked payload and errors.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one stream byte per transaction (valid/ready).
//   rsp_*  : exactly one result transaction per accepted byte, in order:
//            header absorbed, payload byte, empty frame done, or too big.
//   csr_*  : write max_payload; write only while no transaction is in flight.
// Path: an accepted byte is written into the queue, then popped by the parser
//   and its result registered in the result register, from which the result
//   transaction completes.
// Throughput: one byte per cycle sustained while rsp_ready stays high; the
//   parser does one state update per byte.
// Reset: synchronous; the parser waits for the first header byte,
//   max_payload returns to its largest value, the queue empties.
// Stall: when rsp_ready is low the result register holds and the queue
//   fills; req_ready drops once the QUEUE_DEPTH entries are taken.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_unit
   import wsfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [DATA_W-1:0] rsp_payload_byte,
   output logic [DATA_W-1:0] rsp_frame_flags,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic              rsp_was_masked,
   output logic              rsp_last,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data
);

   logic [LEN_W-1:0] max_payload_ff, max_payload_in;
   wsfd_head_type    head;
   logic             pop;

   // Hold the length limit; take a write whenever the enable is high.
   assign max_payload_in = csr_wr_en ? csr_wr_data : max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= LEN_SAT;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   // Front: accept bytes into a short queue so the input side and the
   // parser stall on their own. In steady flow one entry is taken, so with
   // the default depth a stall of the parser fills the queue and drops
   // req_ready in the cycle after the stall.
   wsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .head          (head),
      .pop           (pop)
   );

   // Back: parse the header, check the length, unmask payload bytes.
   wsfd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .max_payload      (max_payload_ff),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_flags  (rsp_frame_flags),
      .rsp_frame_length (rsp_frame_length),
      .rsp_was_masked   (rsp_was_masked),
      .rsp_last         (rsp_last)
   );

endmodule

### design/wsfd_queue.sv
// ---------------------------------------------------------------------------
// wsfd_queue: input side and byte queue
// Accepts stream bytes and holds them until the parser pops them.
// ---------------------------------------------------------------------------
module wsfd_queue
   import wsfd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_data_byte,
   output wsfd_head_type     head,
   input  logic              pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              do_pop;

   assign req_ready = (count_ff != CNT_FULL);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data_byte;
      end
   end

endmodule

### design/wsfd_parser.sv
// ---------------------------------------------------------------------------
// wsfd_parser: frame header parser and payload unmasker
// Pops one byte per cycle while the result register can take it, advances the frame state, registers the result.
// ---------------------------------------------------------------------------
module wsfd_parser
   import wsfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LEN_W-1:0]  max_payload,
   input  wsfd_head_type     head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [DATA_W-1:0] rsp_payload_byte,
   output logic [DATA_W-1:0] rsp_frame_flags,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic              rsp_was_masked,
   output logic              rsp_last
);

   typedef enum logic [2:0] {
      PH_B0   = 3'd0,
      PH_B1   = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   localparam logic [6:0] CODE_EXT16 = 7'd126;
   localparam logic [6:0] CODE_EXT64 = 7'd127;

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] flags_ff, flags_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              big_ff, big_in;
   logic [2:0]        left_ff, left_in;
   logic [31:0]       key_ff, key_in;
   logic              masked_ff, masked_in;
   logic [1:0]        idx_ff, idx_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;

   logic              valid_ff;
   wsfd_kind_type     kind_ff, kind_in;
   logic [DATA_W-1:0] pay_ff, pay_in;
   logic [DATA_W-1:0] oflags_ff;
   logic [LEN_W-1:0]  olen_ff;
   logic              omasked_ff;
   logic              last_ff, last_in;

   logic [DATA_W-1:0] b;
   logic [6:0]        code;
   logic [DATA_W-1:0] key_byte;
   logic              check_len;

   // Pop whenever the result register is empty or being drained.
   assign pop = head.valid && (!valid_ff || rsp_ready);
   assign b   = head.data;
   assign code = b[6:0];

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      len_in    = len_ff;
      big_in    = big_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      masked_in = masked_ff;
      idx_in    = idx_ff;
      remain_in = remain_ff;
      kind_in   = KIND_HEADER;
      pay_in    = '0;
      last_in   = 1'b0;
      check_len = 1'b0;

      case (phase_ff)
         PH_B1: begin
            masked_in = b[7];
            if (code == CODE_EXT64 || code == CODE_EXT16) begin
               len_in   = '0;
               big_in   = 1'b0;
               // Eight bytes is stored as zero: the count wraps through seven.
               left_in  = (code == CODE_EXT64) ? 3'd0 : 3'd2;
               phase_in = PH_EXT;
            end else begin
               len_in    = LEN_W'(code);
               big_in    = 1'b0;
               check_len = 1'b1;
            end
         end
         PH_EXT: begin
            big_in  = big_ff || (len_ff[LEN_W-1:LEN_W-8] != '0);
            len_in  = {len_ff[LEN_W-9:0], b};
            left_in = left_ff - 1'b1;
            if (left_in == '0) begin
               check_len = 1'b1;
            end
         end
         PH_MASK: begin
            key_in  = {key_ff[23:0], b};
            left_in = left_ff - 1'b1;
            if (left_in == '0) begin
               idx_in = '0;
               if (remain_ff == '0) begin
                  phase_in = PH_B0;
                  kind_in  = KIND_EMPTY;
                  last_in  = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            pay_in    = b ^ (masked_ff ? key_byte : '0);
            kind_in   = KIND_PAYLOAD;
            idx_in    = idx_ff + 1'b1;
            remain_in = remain_ff - 1'b1;
            if (remain_in == '0) begin
               last_in  = 1'b1;
               idx_in   = '0;
               phase_in = PH_B0;
            end
         end
         default: begin
            flags_in  = b;
            len_in    = '0;
            big_in    = 1'b0;
            key_in    = '0;
            masked_in = 1'b0;
            idx_in    = '0;
            remain_in = '0;
            left_in   = '0;
            phase_in  = PH_B1;
         end
      endcase

      // Length complete: reject, go to the key, finish empty, or stream data.
      if (check_len) begin
         if (big_in || (len_in > max_payload)) begin
            phase_in = PH_B0;
            kind_in  = KIND_TOO_BIG;
         end else begin
            remain_in = len_in;
            if (masked_in) begin
               phase_in = PH_MASK;
               left_in  = 3'd4;
            end else if (len_in == '0) begin
               phase_in = PH_B0;
               kind_in  = KIND_EMPTY;
               last_in  = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_B0;
         flags_ff  <= '0;
         len_ff    <= '0;
         big_ff    <= 1'b0;
         left_ff   <= '0;
         key_ff    <= '0;
         masked_ff <= 1'b0;
         idx_ff    <= '0;
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            flags_ff  <= flags_in;
            len_ff    <= len_in;
            big_ff    <= big_in;
            left_ff   <= left_in;
            key_ff    <= key_in;
            masked_ff <= masked_in;
            idx_ff    <= idx_in;
            remain_ff <= remain_in;
            valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff    <= kind_in;
         pay_ff     <= pay_in;
         oflags_ff  <= flags_in;
         olen_ff    <= big_in ? LEN_SAT : len_in;
         omasked_ff <= masked_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = pay_ff;
   assign rsp_frame_flags  = oflags_ff;
   assign rsp_frame_length = olen_ff;
   assign rsp_was_masked   = omasked_ff;
   assign rsp_last         = last_ff;

`ifndef NO_ASSERTIONS
   a_first_byte_advances: assert property (@(posedge clock) disable iff (reset)
      (pop && phase_ff == PH_B0) |=> (phase_ff == PH_B1))
      else $error("first header byte did not advance to second byte");

   a_reject_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TOO_BIG) |-> !rsp_last)
      else $error("rejected frame marked last");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remain_ff != '0))
      else $error("payload phase with no bytes remaining");
`endif

endmodule

### sim/websocket_frame_deframer_unit_tb.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer_unit_tb: self-checking bench for the frame deframer
// Streams framed bytes into the parser under random back-pressure, predicts
// every result transaction with a behavioral frame parser and compares them
// field by field, across several max_payload settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module websocket_frame_deframer_unit_tb;
   import wsfd_pkg::*;

   // Length codes carried in the low seven bits of the second header byte.
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // Length field encodings used when building frames.
   localparam int ENC_SHORT = 0;
   localparam int ENC_EXT16 = 1;
   localparam int ENC_EXT64 = 2;

   localparam int BYTES_PER_PHASE = 130;
   localparam int MAX_PRINTED     = 200;

   typedef enum logic [2:0] {
      ST_HDR0,
      ST_HDR1,
      ST_EXTLEN,
      ST_KEY,
      ST_PAYLOAD
   } parse_state_type;

   typedef struct {
      wsfd_kind_type     kind;
      logic [DATA_W-1:0] payload;
      logic [DATA_W-1:0] flags;
      logic [LEN_W-1:0]  length;
      logic              masked;
      logic              last;
   } deframe_result_type;

   // ------------------------------------------------------------------------
   // Frame parser prediction and result checking
   // ------------------------------------------------------------------------
   class deframe_scoreboard;
      parse_state_type    state;
      logic [DATA_W-1:0]  flags_q;
      logic [63:0]        len_acc;
      logic [3:0]         field_left;
      logic [31:0]        key;
      logic               key_on;
      logic [1:0]         key_pos;
      logic [LEN_W-1:0]   remaining;
      logic [LEN_W-1:0]   max_len;
      deframe_result_type expected_q[$];
      int                 errors;

      function new();
         state      = ST_HDR0;
         flags_q    = '0;
         len_acc    = '0;
         field_left = '0;
         key        = '0;
         key_on     = 1'b0;
         key_pos    = '0;
         remaining  = '0;
         max_len    = LEN_SAT;
         errors     = 0;
      endfunction

      function void set_max_payload(logic [LEN_W-1:0] v);
         max_len = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      // Length is complete: reject it, or move on to the key or the payload.
      function wsfd_kind_type close_length(inout logic last_o);
         if (len_acc > {33'd0, max_len}) begin
            state = ST_HDR0;
            return KIND_TOO_BIG;
         end
         remaining = len_acc[LEN_W-1:0];
         if (key_on) begin
            state      = ST_KEY;
            field_left = 4'd4;
            return KIND_HEADER;
         end
         if (remaining == '0) begin
            state  = ST_HDR0;
            last_o = 1'b1;
            return KIND_EMPTY;
         end
         state = ST_PAYLOAD;
         return KIND_HEADER;
      endfunction

      function void note_byte(logic [DATA_W-1:0] b);
         deframe_result_type r;
         logic [DATA_W-1:0]  k;
         r.kind    = KIND_HEADER;
         r.payload = '0;
         r.last    = 1'b0;
         case (state)
            ST_HDR1: begin
               key_on = b[7];
               if (b[6:0] == LEN_CODE_64 || b[6:0] == LEN_CODE_16) begin
                  len_acc    = '0;
                  field_left = (b[6:0] == LEN_CODE_64) ? 4'd8 : 4'd2;
                  state      = ST_EXTLEN;
               end else begin
                  len_acc = {57'd0, b[6:0]};
                  r.kind  = close_length(r.last);
               end
            end
            ST_EXTLEN: begin
               len_acc    = {len_acc[55:0], b};
               field_left = field_left - 4'd1;
               if (field_left == '0)
                  r.kind = close_length(r.last);
            end
            ST_KEY: begin
               key        = {key[23:0], b};
               field_left = field_left - 4'd1;
               if (field_left == '0) begin
                  key_pos = '0;
                  if (remaining == '0) begin
                     state  = ST_HDR0;
                     r.kind = KIND_EMPTY;
                     r.last = 1'b1;
                  end else begin
                     state = ST_PAYLOAD;
                  end
               end
            end
            ST_PAYLOAD: begin
               // first key byte on the wire unmasks payload byte 0
               k         = key_on ? key[8*(3-key_pos) +: 8] : '0;
               r.payload = b ^ k;
               r.kind    = KIND_PAYLOAD;
               key_pos   = key_pos + 2'd1;
               remaining = remaining - 1'b1;
               if (remaining == '0) begin
                  r.last  = 1'b1;
                  key_pos = '0;
                  state   = ST_HDR0;
               end
            end
            default: begin
               flags_q    = b;
               len_acc    = '0;
               key        = '0;
               key_on     = 1'b0;
               key_pos    = '0;
               remaining  = '0;
               field_left = '0;
               state      = ST_HDR1;
            end
         endcase
         r.flags  = flags_q;
         r.length = (len_acc > {33'd0, LEN_SAT}) ? LEN_SAT : len_acc[LEN_W-1:0];
         r.masked = key_on;
         expected_q.push_back(r);
      endfunction

      task check_result(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] payload,
                        logic [DATA_W-1:0] flags, logic [LEN_W-1:0] length,
                        logic masked, logic last);
         deframe_result_type e;
         if (expected_q.size() == 0) begin
            report("result transaction with no byte outstanding");
         end else begin
            e = expected_q.pop_front();
            if (kind !== e.kind)
               report($sformatf("kind got %0d want %0d", kind, e.kind));
            if (payload !== e.payload)
               report($sformatf("payload_byte got %02h want %02h", payload, e.payload));
            if (flags !== e.flags)
               report($sformatf("frame_flags got %02h want %02h", flags, e.flags));
            if (length !== e.length)
               report($sformatf("frame_length got %0d want %0d", length, e.length));
            if (masked !== e.masked)
               report($sformatf("was_masked got %0b want %0b", masked, e.masked));
            if (last !== e.last)
               report($sformatf("last got %0b want %0b", last, e.last));
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, DUT and signals
   // ------------------------------------------------------------------------
   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_data_byte    = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [DATA_W-1:0] rsp_payload_byte;
   logic [DATA_W-1:0] rsp_frame_flags;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic              rsp_was_masked;
   logic              rsp_last;
   logic              csr_wr_en        = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data      = '0;

   deframe_scoreboard sb = new();

   int                sent_bytes   = 0;
   logic [LEN_W-1:0]  cur_max      = LEN_SAT;
   // Burst control: while a burst runs, that side never idles.
   int                req_run_left = 0;
   bit                req_burst    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   websocket_frame_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_flags  (rsp_frame_flags),
      .rsp_frame_length (rsp_frame_length),
      .rsp_was_masked   (rsp_was_masked),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Monitors: sample both channels at the rising edge
   // ------------------------------------------------------------------------
   // Predict the result of every byte the unit accepts.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_byte(req_data_byte);
   end

   // Compare every delivered result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_kind, rsp_payload_byte, rsp_frame_flags,
                         rsp_frame_length, rsp_was_masked, rsp_last);
   end

   // ------------------------------------------------------------------------
   // Result side: stall a random number of cycles before each transaction,
   // with stretches of no stall at all.
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      int run_left;
      bit burst;
      run_left = 0;
      burst    = 1'b0;
      @(negedge clock);
      forever begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            burst    = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         stall = burst ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         // hold ready until a result transaction completes
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Byte side
   // ------------------------------------------------------------------------
   // Offer one byte after a random gap and hold it until taken.
   task send_byte(logic [DATA_W-1:0] b);
      int gap;
      if (req_run_left == 0) begin
         req_run_left = $urandom_range(10, 60);
         req_burst    = ($urandom_range(0, 3) == 0);
      end
      req_run_left--;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
   endtask

   // Build one frame. A negative body_bytes sends the header alone; a body
   // shorter than the length leaves the frame cut off.
   task send_frame(logic [DATA_W-1:0] flags, logic mask, logic [63:0] len,
                   int enc, int body_bytes);
      send_byte(flags);
      case (enc)
         ENC_SHORT: begin
            send_byte({mask, len[6:0]});
         end
         ENC_EXT16: begin
            send_byte({mask, LEN_CODE_16});
            for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
         end
         default: begin
            send_byte({mask, LEN_CODE_64});
            for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
         end
      endcase
      if (body_bytes >= 0) begin
         if (mask) repeat (4) send_byte(8'($urandom));
         repeat (body_bytes) send_byte(8'($urandom));
      end
   endtask

   // Mostly well-formed frames with random content, some oversized, some
   // cut short, and a little line noise.
   task random_frame();
      int          sel;
      int          enc;
      logic [63:0] len;
      logic        mask;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
         mask = 1'($urandom_range(0, 1));
         enc  = ENC_SHORT;
         sel  = $urandom_range(0, 99);
         if (sel < 12) begin
            len = 64'd0;
         end else if (sel < 65) begin
            len = 64'($urandom_range(1, 20));
         end else if (sel < 78) begin
            len = 64'($urandom_range(21, 125));
         end else if (sel < 90) begin
            // small length carried in an extended field
            len = 64'($urandom_range(0, 300));
            enc = $urandom_range(ENC_EXT16, ENC_EXT64);
         end else begin
            len = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
            if (len <= 64'(cur_max))
               len = 64'(cur_max) + 64'd1 + 64'($urandom_range(0, 500));
            if (len >= 64'd126 && len < 64'd65536)
               enc = $urandom_range(ENC_EXT16, ENC_EXT64);
         end
         if (enc == ENC_SHORT && len >= 64'd126)
            enc = (len < 64'd65536) ? ENC_EXT16 : ENC_EXT64;
         if (len > 64'(cur_max))
            send_frame(8'($urandom), mask, len, enc, -1);
         else if ($urandom_range(0, 19) == 0)
            send_frame(8'($urandom), mask, len, enc, $urandom_range(0, int'(len)));
         else
            send_frame(8'($urandom), mask, len, enc, int'(len));
      end
   endtask

   // Drain all outstanding results, then let the pipeline settle.
   task wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write max_payload while nothing is in flight.
   task write_max_payload(logic [LEN_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_max_payload(v);
      cur_max = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [DATA_W-1:0] directed_q[$];
      logic [LEN_W-1:0]  phase_max[6];
      int                phase_end;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: unmasked empty frame, masked empty frame (completion on the
      // last key byte), masked short payload with key rotation and extreme
      // byte values, then a 64-bit length of all ones (too big, saturated).
      directed_q = '{8'h89, 8'h00,
                     8'h8A, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                     8'h81, 8'h83, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'h00, 8'hA5,
                     8'h02, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF};
      foreach (directed_q[i]) send_byte(directed_q[i]);

      // Settings: reset value first, then a limit of one, zero (everything
      // nonzero rejected), a small random one, one that admits extended
      // lengths, and the largest written back explicitly.
      phase_max = '{LEN_SAT, 31'd1, 31'd0, 31'($urandom_range(2, 40)), 31'd150, LEN_SAT};
      foreach (phase_max[p]) begin
         if (p != 0) write_max_payload(phase_max[p]);
         phase_end = sent_bytes + BYTES_PER_PHASE;
         while (sent_bytes < phase_end) random_frame();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
